// ===== rtl/rdc_pkg.sv =====
// shared types and constants for the rst digital controller
// no dependencies; imported by rdc_ctrl, rdc_datapath and the top level
package rdc_pkg;

  localparam int MAX_ORDER   = 16;
  localparam int IDX_W       = $clog2(MAX_ORDER);
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 18;
  localparam int PROD_W      = COEF_W + SAMPLE_W;
  localparam int ACC_W       = 48;
  localparam int INV_W       = 24;
  localparam int SPLIT_W     = ACC_W / 2;
  localparam int FULL_W      = ACC_W + INV_W;
  localparam int SCALE_SHIFT = 28;
  localparam int U_W         = FULL_W - SCALE_SHIFT;
  localparam int ORDER_W     = 5;
  localparam int OP_W        = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_R_ORDER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_T_ORDER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_S_ORDER = 3'd5;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 3'd0,
    OP_LOAD_R = 3'd1,
    OP_LOAD_T = 3'd2,
    OP_LOAD_S = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    TAP_T = 2'd0,
    TAP_R = 2'd1,
    TAP_S = 2'd2
  } tap_sel_t;

  typedef struct packed {
    logic             coef_wr;
    tap_sel_t         coef_sel;
    logic             hist_clr;
    logic             hist_push;
    logic             mac_en;
    tap_sel_t         mac_sel;
    logic [IDX_W-1:0] mac_idx;
    logic             scale_lo;
    logic             scale_hi;
    logic             scale_sum;
    logic             out_load;
    logic             out_err;
  } rdc_cmd_t;

  typedef struct packed {
    logic             bounds_bad;
    logic [IDX_W-1:0] t_last;
    logic [IDX_W-1:0] r_last;
    logic [IDX_W-1:0] s_last;
  } rdc_sts_t;

endpackage

// ===== rtl/rdc_datapath.sv =====
// datapath: configuration registers, coefficient stores, history lines,
// shared mac, two-part reciprocal scaling, clamp and output register; uses rdc_pkg
module rdc_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [rdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rdc_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
  input  logic [rdc_pkg::IDX_W-1:0]            in_coef_index,
  input  logic signed [rdc_pkg::COEF_W-1:0]    in_coef_value,
  input  logic signed [rdc_pkg::SAMPLE_W-1:0]  in_reference,
  input  logic signed [rdc_pkg::SAMPLE_W-1:0]  in_measure,
  input  rdc_pkg::rdc_cmd_t                    cmd,
  output rdc_pkg::rdc_sts_t                    sts,
  output logic signed [rdc_pkg::SAMPLE_W-1:0]  out_control,
  output logic                                 out_saturated,
  output logic                                 out_config_error
);
  import rdc_pkg::*;

  logic signed [SAMPLE_W-1:0] lower_r, upper_r;
  logic [INV_W-1:0]           inv_r;
  logic [ORDER_W-1:0]         r_order_r, t_order_r, s_order_r;

  logic signed [COEF_W-1:0]   r_coefs_r [MAX_ORDER];
  logic signed [COEF_W-1:0]   t_coefs_r [MAX_ORDER];
  logic signed [COEF_W-1:0]   s_coefs_r [MAX_ORDER];
  logic signed [SAMPLE_W-1:0] ref_hist_r  [MAX_ORDER];
  logic signed [SAMPLE_W-1:0] meas_hist_r [MAX_ORDER];
  logic signed [SAMPLE_W-1:0] out_hist_r  [MAX_ORDER];
  logic signed [SAMPLE_W-1:0] last_out_r;

  logic signed [PROD_W-1:0]   prod_r;
  logic                       prod_vld_r;
  logic                       prod_sub_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]           plo_r;
  logic signed [ACC_W-1:0]    phi_r;
  logic signed [U_W-1:0]      u_r;

  logic signed [SAMPLE_W-1:0] ctrl_r;
  logic                       sat_r;
  logic                       err_r;

  // order register to last tap index: zero acts as one, above max acts as max
  function automatic logic [IDX_W-1:0] last_tap(input logic [ORDER_W-1:0] order);
    logic [IDX_W-1:0] res;
    if (order == '0) begin
      res = '0;
    end else if (32'(order) > MAX_ORDER) begin
      res = IDX_W'(MAX_ORDER - 1);
    end else begin
      res = IDX_W'(order - ORDER_W'(1));
    end
    return res;
  endfunction

  assign sts.bounds_bad = (lower_r > upper_r);
  assign sts.t_last     = last_tap(t_order_r);
  assign sts.r_last     = last_tap(r_order_r);
  assign sts.s_last     = last_tap(s_order_r);

  // tap read and product
  logic signed [COEF_W-1:0]   tap_coef;
  logic signed [SAMPLE_W-1:0] tap_smp;
  logic signed [PROD_W-1:0]   prod_nxt;

  always_comb begin
    unique case (cmd.mac_sel)
      TAP_T: begin
        tap_coef = t_coefs_r[cmd.mac_idx];
        tap_smp  = ref_hist_r[cmd.mac_idx];
      end
      TAP_R: begin
        tap_coef = r_coefs_r[cmd.mac_idx];
        tap_smp  = meas_hist_r[cmd.mac_idx];
      end
      TAP_S: begin
        tap_coef = s_coefs_r[cmd.mac_idx];
        tap_smp  = out_hist_r[cmd.mac_idx];
      end
      default: begin
        tap_coef = '0;
        tap_smp  = '0;
      end
    endcase
  end

  assign prod_nxt = tap_coef * tap_smp;

  // saturating accumulate, one guard bit
  logic signed [ACC_W:0]   acc_ext, prod_ext, sum_ext;
  logic signed [ACC_W-1:0] acc_nxt;

  assign acc_ext  = {acc_r[ACC_W-1], acc_r};
  assign prod_ext = (ACC_W+1)'(prod_r);
  assign sum_ext  = prod_sub_r ? (acc_ext - prod_ext) : (acc_ext + prod_ext);

  always_comb begin
    if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
      acc_nxt = sum_ext[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_nxt = sum_ext[ACC_W-1:0];
    end
  end

  // acc * inv split into an unsigned low half and a signed high half
  logic [SPLIT_W-1:0]      acc_lo;
  logic [ACC_W-1:0]        plo_nxt;
  logic signed [ACC_W:0]   phi_full;
  logic [FULL_W-1:0]       full_nxt;

  assign acc_lo   = acc_r[SPLIT_W-1:0];
  assign plo_nxt  = acc_lo * inv_r;
  assign phi_full = $signed(acc_r[ACC_W-1:SPLIT_W]) * $signed({1'b0, inv_r});
  assign full_nxt = {phi_r, {SPLIT_W{1'b0}}} + {{(FULL_W-ACC_W){1'b0}}, plo_r};

  // clamp against the bounds
  logic signed [U_W-1:0]      lower_ext, upper_ext;
  logic                       above, below;
  logic signed [SAMPLE_W-1:0] clamp_val;

  assign lower_ext = U_W'(lower_r);
  assign upper_ext = U_W'(upper_r);
  assign above     = (u_r > upper_ext);
  assign below     = (u_r < lower_ext);

  always_comb begin
    priority if (above) begin
      clamp_val = upper_r;
    end else if (below) begin
      clamp_val = lower_r;
    end else begin
      clamp_val = u_r[SAMPLE_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      upper_r   <= {1'b0, {(SAMPLE_W-1){1'b1}}};
      inv_r     <= INV_W'(65536);
      r_order_r <= ORDER_W'(1);
      t_order_r <= ORDER_W'(1);
      s_order_r <= ORDER_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LOWER:   lower_r   <= cfg_wr_data[SAMPLE_W-1:0];
        CFG_UPPER:   upper_r   <= cfg_wr_data[SAMPLE_W-1:0];
        CFG_INV:     inv_r     <= cfg_wr_data[INV_W-1:0];
        CFG_R_ORDER: r_order_r <= cfg_wr_data[ORDER_W-1:0];
        CFG_T_ORDER: t_order_r <= cfg_wr_data[ORDER_W-1:0];
        CFG_S_ORDER: s_order_r <= cfg_wr_data[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficient stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        r_coefs_r[i] <= '0;
        t_coefs_r[i] <= '0;
        s_coefs_r[i] <= '0;
      end
    end else if (cmd.coef_wr) begin
      unique case (cmd.coef_sel)
        TAP_R:   r_coefs_r[in_coef_index] <= in_coef_value;
        TAP_T:   t_coefs_r[in_coef_index] <= in_coef_value;
        TAP_S:   s_coefs_r[in_coef_index] <= in_coef_value;
        default: ;
      endcase
    end
  end

  // history lines, newest at tap 0
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.hist_clr) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        ref_hist_r[i]  <= '0;
        meas_hist_r[i] <= '0;
        out_hist_r[i]  <= '0;
      end
      last_out_r <= '0;
    end else begin
      if (cmd.hist_push) begin
        for (int i = 1; i < MAX_ORDER; i++) begin
          ref_hist_r[i]  <= ref_hist_r[i-1];
          meas_hist_r[i] <= meas_hist_r[i-1];
          out_hist_r[i]  <= out_hist_r[i-1];
        end
        ref_hist_r[0]  <= in_reference;
        meas_hist_r[0] <= in_measure;
        out_hist_r[0]  <= last_out_r;
      end
      if (cmd.out_load && !cmd.out_err) begin
        last_out_r <= clamp_val;
      end
    end
  end

  // mac pipeline valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mac_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      prod_r     <= prod_nxt;
      prod_sub_r <= (cmd.mac_sel != TAP_T);
    end
    if (cmd.hist_push) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (cmd.scale_lo) begin
      plo_r <= plo_nxt;
    end
    if (cmd.scale_hi) begin
      phi_r <= phi_full[ACC_W-1:0];
    end
    if (cmd.scale_sum) begin
      u_r <= full_nxt[FULL_W-1:SCALE_SHIFT];
    end
    if (cmd.out_load) begin
      if (cmd.out_err) begin
        ctrl_r <= last_out_r;
        sat_r  <= 1'b0;
        err_r  <= 1'b1;
      end else begin
        ctrl_r <= clamp_val;
        sat_r  <= above | below;
        err_r  <= 1'b0;
      end
    end
  end

  assign out_control      = ctrl_r;
  assign out_saturated    = sat_r;
  assign out_config_error = err_r;

endmodule

// ===== rtl/rdc_ctrl.sv =====
// controller: decodes requests and sequences mac taps, scaling and output
// uses rdc_pkg; drives rdc_datapath through rdc_cmd_t
module rdc_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rdc_pkg::OP_W-1:0]      in_opcode,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  rdc_pkg::rdc_sts_t             sts,
  output rdc_pkg::rdc_cmd_t             cmd
);
  import rdc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_EMIT,
    S_ERR
  } state_t;

  state_t           state_r;
  tap_sel_t         phase_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;

  logic             accept;
  logic             slot_free;
  logic [IDX_W-1:0] phase_last;
  opcode_t          op;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign op        = opcode_t'(in_opcode);

  always_comb begin
    unique case (phase_r)
      TAP_T:   phase_last = sts.t_last;
      TAP_R:   phase_last = sts.r_last;
      TAP_S:   phase_last = sts.s_last;
      default: phase_last = '0;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mac_sel  = phase_r;
    cmd.mac_idx  = idx_r;
    cmd.coef_sel = TAP_T;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_SAMPLE: cmd.hist_push = !sts.bounds_bad;
            OP_LOAD_R: begin
              cmd.coef_wr  = 1'b1;
              cmd.coef_sel = TAP_R;
            end
            OP_LOAD_T: begin
              cmd.coef_wr  = 1'b1;
              cmd.coef_sel = TAP_T;
            end
            OP_LOAD_S: begin
              cmd.coef_wr  = 1'b1;
              cmd.coef_sel = TAP_S;
            end
            OP_CLEAR:  cmd.hist_clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_MAC:    cmd.mac_en    = 1'b1;
      S_DRAIN: ;
      S_MUL_LO: cmd.scale_lo  = 1'b1;
      S_MUL_HI: cmd.scale_hi  = 1'b1;
      S_SUM:    cmd.scale_sum = 1'b1;
      S_EMIT:   cmd.out_load  = slot_free;
      S_ERR: begin
        cmd.out_load = slot_free;
        cmd.out_err  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= TAP_T;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && op == OP_SAMPLE) begin
            phase_r <= TAP_T;
            idx_r   <= '0;
            state_r <= sts.bounds_bad ? S_ERR : S_MAC;
          end
        end
        S_MAC: begin
          if (idx_r == phase_last) begin
            idx_r <= '0;
            unique case (phase_r)
              TAP_T:   phase_r <= TAP_R;
              TAP_R:   phase_r <= TAP_S;
              default: state_r <= S_DRAIN;
            endcase
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        // last product lands in the accumulator here
        S_DRAIN:  state_r <= S_MUL_LO;
        S_MUL_LO: state_r <= S_MUL_HI;
        S_MUL_HI: state_r <= S_SUM;
        S_SUM:    state_r <= S_EMIT;
        S_EMIT, S_ERR: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rst_digital_controller.sv =====
// top level of the rst digital controller: rdc_ctrl plus rdc_datapath
// uses rdc_pkg
//
//   channel  direction  handshake            payload
//   in       request    in_valid / in_stall  opcode, coef_index, coef_value, reference, measure
//   out      result     out_valid / out_stall control, saturated, config_error
//   cfg      write      cfg_wr_en            cfg_index, cfg_wr_data
//
// a sample request walks every t, r and s tap through the single shared mac,
// then drains it and runs a split 48x24 scaling multiply, sum and emit; no new
// request is taken until the block is idle again; load, clear and unknown requests act in the cycle they are taken
// reset is synchronous, active low; coefficients and histories clear at once
// a result waits in the output register under out_stall while the next request
// is taken; the block only holds in the final state if that register is still full
module rst_digital_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [rdc_pkg::OP_W-1:0]             in_opcode,
  input  logic [rdc_pkg::IDX_W-1:0]            in_coef_index,
  input  logic signed [rdc_pkg::COEF_W-1:0]    in_coef_value,
  input  logic signed [rdc_pkg::SAMPLE_W-1:0]  in_reference,
  input  logic signed [rdc_pkg::SAMPLE_W-1:0]  in_measure,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [rdc_pkg::SAMPLE_W-1:0]  out_control,
  output logic                                 out_saturated,
  output logic                                 out_config_error,
  input  logic                                 cfg_wr_en,
  input  logic [rdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rdc_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);
  import rdc_pkg::*;

  rdc_cmd_t cmd;
  rdc_sts_t sts;

  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_coef_index    (in_coef_index),
    .in_coef_value    (in_coef_value),
    .in_reference     (in_reference),
    .in_measure       (in_measure),
    .cmd              (cmd),
    .sts              (sts),
    .out_control      (out_control),
    .out_saturated    (out_saturated),
    .out_config_error (out_config_error)
  );

endmodule

// ===== tb/tb_top.sv =====
// testbench for rst_digital_controller: randomized request stream with a
// cycle-free predictor of the fixed-point rst control law, checked result by result
// depends on rdc_pkg and the rst_digital_controller top level
module tb_top;
  import rdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int LONG_HOLD      = 300;
  localparam int MAX_REPORTS    = 10;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 105;
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct {
    logic [OP_W-1:0]            opcode;
    logic [IDX_W-1:0]           coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [SAMPLE_W-1:0] reference;
    logic signed [SAMPLE_W-1:0] measure;
  } ctrl_req_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] control;
    logic                       saturated;
    logic                       config_error;
  } ctrl_result_t;

  typedef logic signed [COEF_W-1:0]   coef_line_t [MAX_ORDER];
  typedef logic signed [SAMPLE_W-1:0] sample_line_t [MAX_ORDER];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_opcode = '0;
  logic [IDX_W-1:0] in_coef_index = '0;
  logic signed [COEF_W-1:0] in_coef_value = '0;
  logic signed [SAMPLE_W-1:0] in_reference = '0;
  logic signed [SAMPLE_W-1:0] in_measure = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_control;
  logic out_saturated;
  logic out_config_error;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  rst_digital_controller DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic signed [SAMPLE_W-1:0] lo_bound = -16'sd32768;
  logic signed [SAMPLE_W-1:0] up_bound = 16'sd32767;
  logic [INV_W-1:0] inv_recip = 24'd65536;
  logic [ORDER_W-1:0] r_ord = 5'd1, t_ord = 5'd1, s_ord = 5'd1;
  coef_line_t r_coef = '{default: '0};
  coef_line_t t_coef = '{default: '0};
  coef_line_t s_coef = '{default: '0};
  sample_line_t ref_hist = '{default: '0};
  sample_line_t meas_hist = '{default: '0};
  sample_line_t out_hist = '{default: '0};
  logic signed [SAMPLE_W-1:0] last_ctrl = '0;

  ctrl_req_t    pending_reqs[$];
  ctrl_result_t expected_outputs[$];
  ctrl_req_t    cur_req;

  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0, hold_done = 1'b0;
  int send_gap = 0, recv_gap = 0, hold_left = 0;
  int reqs_accepted = 0, results_checked = 0, mismatches = 0;
  int n_clamped = 0, n_bound_err = 0, n_settings = 0;
  int stuck_cycles = 0;

  function automatic int tap_count(input logic [ORDER_W-1:0] order);
    if (order == 0) return 1;
    if (order > MAX_ORDER) return MAX_ORDER;
    return int'(order);
  endfunction

  // one polynomial walk, each partial sum saturated to the 48-bit accumulator
  function automatic longint mac_taps(input longint acc, input coef_line_t c,
                                      input sample_line_t h, input int n, input bit sub);
    longint p;
    for (int i = 0; i < n; i++) begin
      p = longint'(c[i]) * longint'(h[i]);
      acc = sub ? acc - p : acc + p;
      if (acc > ACC_HI) acc = ACC_HI;
      if (acc < ACC_LO) acc = ACC_LO;
    end
    return acc;
  endfunction

  function automatic void predict_request(input ctrl_req_t r);
    longint acc;
    logic signed [95:0] acc_w, inv_w, prod, u;
    ctrl_result_t res;
    case (r.opcode)
      OP_LOAD_R: r_coef[r.coef_index] = r.coef_value;
      OP_LOAD_T: t_coef[r.coef_index] = r.coef_value;
      OP_LOAD_S: s_coef[r.coef_index] = r.coef_value;
      OP_CLEAR: begin
        ref_hist = '{default: '0};
        meas_hist = '{default: '0};
        out_hist = '{default: '0};
        last_ctrl = '0;
      end
      OP_SAMPLE: begin
        if (lo_bound > up_bound) begin
          // crossed bounds: old output repeated, nothing moves
          res.control = last_ctrl;
          res.saturated = 1'b0;
          res.config_error = 1'b1;
        end else begin
          for (int i = MAX_ORDER - 1; i > 0; i--) begin
            ref_hist[i] = ref_hist[i-1];
            meas_hist[i] = meas_hist[i-1];
            out_hist[i] = out_hist[i-1];
          end
          ref_hist[0] = r.reference;
          meas_hist[0] = r.measure;
          out_hist[0] = last_ctrl;
          acc = mac_taps(0, t_coef, ref_hist, tap_count(t_ord), 1'b0);
          acc = mac_taps(acc, r_coef, meas_hist, tap_count(r_ord), 1'b1);
          acc = mac_taps(acc, s_coef, out_hist, tap_count(s_ord), 1'b1);
          acc_w = acc;
          inv_w = {72'd0, inv_recip};
          prod = acc_w * inv_w;
          u = prod >>> SCALE_SHIFT;
          res.saturated = 1'b0;
          if (u > up_bound) begin
            u = up_bound;
            res.saturated = 1'b1;
          end
          if (u < lo_bound) begin
            u = lo_bound;
            res.saturated = 1'b1;
          end
          res.control = u[SAMPLE_W-1:0];
          res.config_error = 1'b0;
          last_ctrl = res.control;
        end
        expected_outputs.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_request(cur_req);
        reqs_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap == 0 && !quiet && $urandom_range(0, 99) < send_idle_pct)
          send_gap = $urandom_range(1, 5);
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_opcode <= cur_req.opcode;
          in_coef_index <= cur_req.coef_index;
          in_coef_value <= cur_req.coef_value;
          in_reference <= cur_req.reference;
          in_measure <= cur_req.measure;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver stall, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (recv_gap == 0 && !quiet && $urandom_range(0, 99) < recv_idle_pct)
          recv_gap = $urandom_range(1, 5);
        if (recv_gap > 0) begin
          recv_gap--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    ctrl_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: control=%0d sat=%0b err=%0b",
                   out_control, out_saturated, out_config_error);
      end else begin
        want = expected_outputs.pop_front();
        if (out_control !== want.control || out_saturated !== want.saturated ||
            out_config_error !== want.config_error) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: expected control=%0d sat=%0b err=%0b, got control=%0d sat=%0b err=%0b",
                     results_checked, want.control, want.saturated, want.config_error,
                     out_control, out_saturated, out_config_error);
        end
        if (want.saturated) n_clamped++;
        if (want.config_error) n_bound_err++;
        results_checked++;
      end
    end
  end

  // nothing accepted for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= data;
    case (idx)
      CFG_LOWER:   lo_bound = data[SAMPLE_W-1:0];
      CFG_UPPER:   up_bound = data[SAMPLE_W-1:0];
      CFG_INV:     inv_recip = data[INV_W-1:0];
      CFG_R_ORDER: r_ord = data[ORDER_W-1:0];
      CFG_T_ORDER: t_ord = data[ORDER_W-1:0];
      CFG_S_ORDER: s_ord = data[ORDER_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // upper data bits are junk on purpose; only the register width counts
  task automatic set_config(input int lo, input int up, input int inv,
                            input int r_o, input int t_o, input int s_o);
    write_reg(CFG_LOWER, {8'($urandom), 16'(lo)});
    write_reg(CFG_UPPER, {8'($urandom), 16'(up)});
    write_reg(CFG_INV, 24'(inv));
    write_reg(CFG_R_ORDER, {19'($urandom), 5'(r_o)});
    write_reg(CFG_T_ORDER, {19'($urandom), 5'(t_o)});
    write_reg(CFG_S_ORDER, {19'($urandom), 5'(s_o)});
    n_settings++;
    @(negedge clk);
  endtask

  task automatic pick_config(input bit crossed);
    int a, b, lo, up, inv;
    a = $urandom_range(0, 65535) - 32768;
    b = $urandom_range(0, 65535) - 32768;
    case ($urandom_range(0, 3))
      0: begin lo = -32768; up = 32767; end
      1: begin lo = (a < b) ? a : b; up = (a < b) ? b : a; end
      2: begin lo = -int'($urandom_range(0, 2000)); up = $urandom_range(0, 2000); end
      default: begin lo = a; up = a; end
    endcase
    if (crossed) begin
      lo = $urandom_range(1, 32767);
      up = -int'($urandom_range(0, 32768));
    end
    case ($urandom_range(0, 4))
      0: inv = 0;
      1: inv = 24'hFF_FFFF;
      2: inv = 65536;
      3: inv = $urandom_range(1024, 131072);
      default: inv = $urandom_range(0, 24'hFF_FFFF);
    endcase
    set_config(lo, up, inv,
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4),
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4),
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4));
  endtask

  task automatic queue_req(input logic [OP_W-1:0] op, input int idx, input int cv,
                           input int rf, input int ms);
    ctrl_req_t r;
    r.opcode = op;
    r.coef_index = IDX_W'(idx);
    r.coef_value = COEF_W'(cv);
    r.reference = SAMPLE_W'(rf);
    r.measure = SAMPLE_W'(ms);
    pending_reqs.push_back(r);
  endtask

  // mostly samples and loads; coefficients are mostly modest, samples mostly full range
  task automatic queue_random_req();
    int pick, cv, rf, ms;
    pick = $urandom_range(0, 99);
    cv = ($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 8191) - 4096;
    rf = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) - 256 : int'($urandom);
    ms = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) - 256 : int'($urandom);
    if (pick < 58)
      queue_req(OP_SAMPLE, $urandom, cv, rf, ms);
    else if (pick < 93)
      queue_req(OP_W'($urandom_range(OP_LOAD_R, OP_LOAD_S)), $urandom, cv, rf, ms);
    else if (pick < 96)
      queue_req(OP_CLEAR, $urandom, cv, rf, ms);
    else
      queue_req(OP_W'(OP_FIRST_UNUSED + $urandom_range(0, 2)), $urandom, cv, rf, ms);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_outputs.size() != 0);
    // loads and clears give no result and may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 20;
    recv_idle_pct = 20;

    // reset settings: zero coefficients, unit taps, then field extremes
    queue_req(OP_SAMPLE, 0, 0, 0, 0);
    queue_req(OP_LOAD_T, 0, 4096, $urandom, $urandom);
    queue_req(OP_LOAD_R, 0, 4096, $urandom, $urandom);
    queue_req(OP_LOAD_S, 0, 2048, $urandom, $urandom);
    queue_req(OP_SAMPLE, 15, -131072, 32767, 0);
    queue_req(OP_SAMPLE, 0, 131071, -32768, 32767);
    queue_req(OP_SAMPLE, 7, 0, 32767, -32768);
    queue_req(OP_LOAD_T, 15, 131071, 0, 0);
    queue_req(OP_LOAD_R, 15, -131072, -1, -1);
    queue_req(OP_LOAD_S, 15, -131072, 0, 0);
    queue_req(OP_FIRST_UNUSED, 3, 100, 100, 100);
    queue_req(OP_W'(OP_FIRST_UNUSED + 1), 15, -1, -1, -1);
    queue_req(OP_W'(OP_FIRST_UNUSED + 2), 0, 0, 0, 0);
    queue_req(OP_CLEAR, 0, 0, 0, 0);
    queue_req(OP_SAMPLE, 0, 0, 100, -100);
    wait_idle();

    // wide r and t orders (31 behaves as full length), zero s order, largest reciprocal
    set_config(-32768, 32767, 24'hFF_FFFF, 31, 16, 0);
    queue_req(OP_SAMPLE, 0, 0, -32768, 32767);
    queue_req(OP_SAMPLE, 0, 0, 32767, -32768);
    queue_req(OP_SAMPLE, 0, 0, 0, 0);
    wait_idle();

    // zero orders act as one tap, zero reciprocal clamps up to the floor
    set_config(5, 100, 0, 0, 0, 0);
    queue_req(OP_SAMPLE, 0, 0, 1000, 1000);
    wait_idle();

    // crossed bounds: error results, histories frozen; coefficient loads and clears still apply
    set_config(100, -100, 65536, 1, 1, 1);
    queue_req(OP_SAMPLE, 0, 0, 5000, -5000);
    queue_req(OP_LOAD_T, 1, -1, 0, 0);
    queue_req(OP_SAMPLE, 0, 0, -5000, 5000);
    queue_req(OP_CLEAR, 0, 0, 0, 0);
    queue_req(OP_SAMPLE, 0, 0, 1, 1);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      pick_config(p == 4);
      case ($urandom_range(0, 2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 10;
        default: send_idle_pct = 30;
      endcase
      case ($urandom_range(0, 2))
        0: recv_idle_pct = 0;
        1: recv_idle_pct = 10;
        default: recv_idle_pct = 30;
      endcase
      // receiver holds off long while requests keep coming, so the block backs up
      if (p == 1) hold_req = 1'b1;
      if (p == RAND_PHASES - 1) quiet = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) queue_random_req();
      wait_idle();
    end

    $display("%0d requests accepted, %0d results checked: %0d clamped, %0d bound errors",
             reqs_accepted, results_checked, n_clamped, n_bound_err);
    $display("%0d register settings applied, %0d mismatches", n_settings, mismatches);
    if (mismatches == 0 && expected_outputs.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rdc_pkg.sv
rtl/rdc_datapath.sv
rtl/rdc_ctrl.sv
rtl/rst_digital_controller.sv
tb/tb_top.sv
